@@ design/unbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package unbm_pkg;

  localparam logic [7:0] ByteNul    = 8'h00;
  localparam logic [7:0] LeadLatin2 = 8'hC2;
  localparam logic [7:0] LeadLatin1 = 8'hC3;
  localparam logic [7:0] LeadTwoMin = 8'hC4;
  localparam logic [7:0] LeadTwoMax = 8'hDF;
  localparam logic [7:0] LeadThrMin = 8'hE0;
  localparam logic [7:0] LeadThrMax = 8'hEF;
  localparam logic [7:0] LeadFouMin = 8'hF0;
  localparam logic [7:0] LeadFouMax = 8'hF4;
  localparam logic [7:0] ContMin    = 8'h80;
  localparam logic [7:0] ContMax    = 8'hBF;
  localparam logic [7:0] AsciiDig0  = 8'h30;
  localparam logic [7:0] AsciiDig9  = 8'h39;
  localparam logic [7:0] AsciiUpA   = 8'h41;
  localparam logic [7:0] AsciiUpZ   = 8'h5A;
  localparam logic [7:0] AsciiLoA   = 8'h61;
  localparam logic [7:0] AsciiLoZ   = 8'h7A;
  localparam logic [6:0] CaseOffset = 7'd32;

  localparam logic [6:0] CharNone = 7'h00;
  localparam logic [6:0] CharZero = 7'h30;
  localparam logic [6:0] CharNine = 7'h39;
  localparam logic [6:0] CharA    = 7'h61;
  localparam logic [6:0] CharC    = 7'h63;
  localparam logic [6:0] CharD    = 7'h64;
  localparam logic [6:0] CharE    = 7'h65;
  localparam logic [6:0] CharI    = 7'h69;
  localparam logic [6:0] CharN    = 7'h6E;
  localparam logic [6:0] CharO    = 7'h6F;
  localparam logic [6:0] CharS    = 7'h73;
  localparam logic [6:0] CharT    = 7'h74;
  localparam logic [6:0] CharU    = 7'h75;
  localparam logic [6:0] CharY    = 7'h79;
  localparam logic [6:0] CharZ    = 7'h7A;

  // Decode of a byte seen in plain scanning
  typedef struct packed {
    logic       hit;    // byte decides the result
    logic [6:0] ch;
    logic       found;
    logic       latin;  // 0xC3 lead
    logic [1:0] skip;   // continuation bytes to drop
  } unbm_cls_t;

  // Result of one accepted item
  typedef struct packed {
    logic       emit;
    logic [6:0] ch;
    logic       found;
  } unbm_res_t;

  // Folded letter for the byte after 0xC3; CharNone for the multiply/divide signs
  function automatic logic [6:0] latin_fold(input logic [7:0] b);
    logic [6:0] f;
    f = CharNone;
    unique case (b[4:0])
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: f = CharA;
      5'd7:                                      f = CharC;
      5'd8, 5'd9, 5'd10, 5'd11:                  f = CharE;
      5'd12, 5'd13, 5'd14, 5'd15:                f = CharI;
      5'd16:                                     f = CharD;
      5'd17:                                     f = CharN;
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd24:  f = CharO;
      5'd23:                                     f = CharNone;
      5'd25, 5'd26, 5'd27, 5'd28:                f = CharU;
      5'd29:                                     f = CharY;
      5'd30:                                     f = CharT;
      5'd31:                                     f = b[5] ? CharY : CharS;
      default:                                   f = CharNone;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

@@ design/unbm_byte_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface unbm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       end_of_name;

  modport source (output valid, output name_byte, output end_of_name, input ready);
  modport sink   (input valid, input name_byte, input end_of_name, output ready);
endinterface

`default_nettype wire

@@ design/unbm_bucket_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface unbm_bucket_if;
  logic       valid;
  logic       ready;
  logic [6:0] bucket_char;
  logic       found_char;

  modport source (output valid, output bucket_char, output found_char, input ready);
  modport sink   (input valid, input bucket_char, input found_char, output ready);
endinterface

`default_nettype wire

@@ design/unbm_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none

module unbm_classify (
  input  logic [7:0]         byte_i,
  output unbm_pkg::unbm_cls_t cls_o
);
  import unbm_pkg::*;

  always_comb begin
    cls_o = '0;
    priority if (byte_i == ByteNul) begin
      cls_o.hit = 1'b1;
      cls_o.ch  = CharZero;
    end else if (byte_i == LeadLatin2) begin
      cls_o.skip = 2'd1;
    end else if (byte_i == LeadLatin1) begin
      cls_o.latin = 1'b1;
    end else if (byte_i >= LeadTwoMin && byte_i <= LeadTwoMax) begin
      cls_o.skip = 2'd1;
    end else if (byte_i >= LeadThrMin && byte_i <= LeadThrMax) begin
      cls_o.skip = 2'd2;
    end else if (byte_i >= LeadFouMin && byte_i <= LeadFouMax) begin
      cls_o.skip = 2'd3;
    end else if ((byte_i >= AsciiDig0 && byte_i <= AsciiDig9) ||
                 (byte_i >= AsciiLoA && byte_i <= AsciiLoZ)) begin
      cls_o.hit   = 1'b1;
      cls_o.found = 1'b1;
      cls_o.ch    = byte_i[6:0];
    end else if (byte_i >= AsciiUpA && byte_i <= AsciiUpZ) begin
      cls_o.hit   = 1'b1;
      cls_o.found = 1'b1;
      cls_o.ch    = byte_i[6:0] + CaseOffset;
    end else begin
      cls_o = '0;
    end
  end

endmodule

`default_nettype wire

@@ design/unbm_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module unbm_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output unbm_pkg::unbm_res_t res_o
);
  import unbm_pkg::*;

  typedef enum logic [1:0] {
    PhScan  = 2'd0,
    PhLatin = 2'd1,
    PhDone  = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] skip_q, skip_d;
  unbm_cls_t  cls;
  logic [6:0] fold;
  logic       already;
  logic       hit;
  logic [6:0] ch;
  logic       found;

  unbm_classify u_classify (
    .byte_i (byte_i),
    .cls_o  (cls)
  );

  assign fold = latin_fold(byte_i);

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    hit     = 1'b0;
    ch      = CharZero;
    found   = 1'b0;
    already = 1'b0;
    unique case (phase_q)
      PhLatin: begin
        phase_d = PhScan;
        if (byte_i >= ContMin && byte_i <= ContMax) begin
          if (fold != CharNone) begin
            hit   = 1'b1;
            ch    = fold;
            found = 1'b1;
          end
        end else begin
          // broken sequence: the byte starts over as a fresh one
          hit   = cls.hit;
          ch    = cls.ch;
          found = cls.found;
          skip_d = cls.skip;
          if (cls.latin) phase_d = PhLatin;
        end
      end
      PhScan: begin
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
        end else begin
          hit    = cls.hit;
          ch     = cls.ch;
          found  = cls.found;
          skip_d = cls.skip;
          if (cls.latin) phase_d = PhLatin;
        end
      end
      default: already = 1'b1;
    endcase

    res_o.emit  = 1'b0;
    res_o.ch    = ch;
    res_o.found = found;
    if (hit) begin
      phase_d    = PhDone;
      skip_d     = 2'd0;
      res_o.emit = accept_i;
    end else if (last_i && !already) begin
      res_o.emit  = accept_i;
      res_o.ch    = CharZero;
      res_o.found = 1'b0;
    end

    if (last_i) begin
      phase_d = PhScan;
      skip_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhScan;
      skip_q  <= 2'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8_name_bucket_mapper_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 name bucket mapper: takes one byte of a name per cycle on in_i
// unless out_o stalls, and gives one item per name on out_o, the first
// letter or digit folded to '0'-'9' or 'a'-'z' (Latin-1 accents after 0xC3
// fold to the base letter), or '0' with found_char low when the name ends
// undecided or a zero byte decides it. The result of the deciding byte, or
// of the last byte, appears in the output register in the cycle after that
// byte is accepted. A single output register decouples the sides: a byte
// is accepted whenever that register is empty or being taken in that cycle.
module utf8_name_bucket_mapper_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  unbm_byte_if.sink     in_i,
  unbm_bucket_if.source out_o
);
  import unbm_pkg::*;

  logic       in_accept;
  unbm_res_t  res;
  logic       out_valid_q;
  logic [6:0] out_char_q;
  logic       out_found_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  unbm_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (in_i.name_byte),
    .last_i   (in_i.end_of_name),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.emit) begin
      out_char_q  <= res.ch;
      out_found_q <= res.found;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.bucket_char = out_char_q;
  assign out_o.found_char  = out_found_q;

  // a new result only follows an accepted byte
  a_emit_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_accept))
    else $error("result without accepted byte");

  // an accepted byte that emits a result always makes the output valid
  a_last_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && res.emit |=> out_valid_q)
    else $error("result lost");

  a_default_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_char_q == CharZero)
    else $error("default result not '0'");

  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_found_q |->
      ((out_char_q >= CharZero && out_char_q <= CharNine) ||
       (out_char_q >= CharA && out_char_q <= CharZ)))
    else $error("bucket char out of range");

endmodule

`default_nettype wire

@@ tb/sv/utf8_name_bucket_mapper_unit_test.sv @@
`timescale 1ns / 1ps

import unbm_pkg::*;

typedef struct packed {
  logic [6:0] ch;
  logic       found;
} bucket_t;

localparam logic [1:0] PhScan  = 2'd0;
localparam logic [1:0] PhLatin = 2'd1;
localparam logic [1:0] PhDone  = 2'd2;

localparam logic [7:0] NoChar   = 8'hFF;
localparam logic [7:0] MulSign  = 8'h97;
localparam logic [7:0] DivSign  = 8'hB7;
localparam logic [7:0] ByteLast = 8'hFF;

// base letter after 0xC3, by low five bits; '-' marks the multiply/divide slot
localparam logic [255:0] LatinBase = "aaaaaaaceeeeiiiidnooooo-ouuuuyts";

class bucket_scoreboard;
  logic [1:0] phase;
  logic [1:0] skip_left;
  bucket_t    bucket_q[$];
  int         errors;
  int         checked;
  int         letters;
  int         scanned;

  function new();
    phase     = PhScan;
    skip_left = 2'd0;
    errors    = 0;
    checked   = 0;
    letters   = 0;
    scanned   = 0;
  endfunction

  function logic [7:0] latin_base(logic [7:0] b);
    logic [7:0] c;
    c = LatinBase[8*(31 - int'(b[4:0])) +: 8];
    if (c == "-") return NoChar;
    if (b[4:0] == 5'd31 && b >= 8'hA0) return {1'b0, CharY};
    return c;
  endfunction

  // plain scanning decode; NoChar when the byte decides nothing
  function logic [7:0] scan_byte(logic [7:0] b, output logic found);
    found = 1'b0;
    if (b == ByteNul) return {1'b0, CharZero};
    if (b == LeadLatin2) begin
      skip_left = 2'd1;
      return NoChar;
    end
    if (b == LeadLatin1) begin
      phase = PhLatin;
      return NoChar;
    end
    if (b >= LeadTwoMin && b <= LeadTwoMax) begin
      skip_left = 2'd1;
      return NoChar;
    end
    if (b >= LeadThrMin && b <= LeadThrMax) begin
      skip_left = 2'd2;
      return NoChar;
    end
    if (b >= LeadFouMin && b <= LeadFouMax) begin
      skip_left = 2'd3;
      return NoChar;
    end
    if ((b >= AsciiDig0 && b <= AsciiDig9) || (b >= AsciiLoA && b <= AsciiLoZ)) begin
      found = 1'b1;
      return b;
    end
    if (b >= AsciiUpA && b <= AsciiUpZ) begin
      found = 1'b1;
      return b + {1'b0, CaseOffset};
    end
    return NoChar;
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    logic [7:0] ch;
    logic       found;
    logic       decided;
    bucket_t    exp;
    decided = (phase >= PhDone);
    ch      = NoChar;
    found   = 1'b0;
    if (!decided) begin
      scanned++;
      if (phase == PhLatin) begin
        phase = PhScan;
        if (b >= ContMin && b <= ContMax) begin
          ch    = latin_base(b);
          found = (ch != NoChar);
        end else begin
          ch = scan_byte(b, found);
        end
      end else if (skip_left != 2'd0) begin
        skip_left--;
      end else begin
        ch = scan_byte(b, found);
      end
    end
    if (ch != NoChar) begin
      phase     = PhDone;
      skip_left = 2'd0;
      exp.ch    = ch[6:0];
      exp.found = found;
      bucket_q  = {bucket_q, exp};
    end else if (last && !decided) begin
      exp.ch    = CharZero;
      exp.found = 1'b0;
      bucket_q  = {bucket_q, exp};
    end
    if (last) begin
      phase     = PhScan;
      skip_left = 2'd0;
    end
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_bucket(logic [6:0] ch, logic found);
    bucket_t exp;
    if (bucket_q.size() == 0) begin
      report($sformatf("unexpected bucket item ch=%h found=%b", ch, found));
    end else begin
      exp = bucket_q.pop_front();
      checked++;
      if (found) letters++;
      if (ch !== exp.ch)
        report($sformatf("bucket_char %h, expected %h", ch, exp.ch));
      if (found !== exp.found)
        report($sformatf("found_char %b, expected %b (char %h)", found, exp.found, exp.ch));
    end
  endtask
endclass

module utf8_name_bucket_mapper_unit_test;

  localparam int IdleLimit = 200;

  logic clk_i;
  logic rst_ni;

  unbm_byte_if   byte_if();
  unbm_bucket_if bucket_if();

  utf8_name_bucket_mapper_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (bucket_if)
  );

  bucket_scoreboard sb = new();

  logic [7:0] name_buf[$];
  bit         calm;
  int         names;
  int         bytes_sent;
  int         idle_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready)
        sb.note_byte(byte_if.name_byte, byte_if.end_of_name);
      if (bucket_if.valid && bucket_if.ready)
        sb.check_bucket(bucket_if.bucket_char, bucket_if.found_char);
    end
  end

  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (bucket_if.valid && bucket_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IdleLimit) begin
      $display("timeout: no item moved for %0d cycles", IdleLimit);
      $display("utf8_name_bucket_mapper_unit_test failed");
      $finish;
    end
  end

  // result side: random stalls
  initial begin
    int gap;
    bucket_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        bucket_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      bucket_if.ready <= 1'b1;
      do @(posedge clk_i); while (!bucket_if.valid);
    end
  end

  task push_byte(logic [7:0] b, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.name_byte   <= b;
    byte_if.end_of_name <= last;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  task send_name();
    for (int i = 0; i < name_buf.size(); i++)
      push_byte(name_buf[i], i == name_buf.size() - 1);
    names++;
  endtask

  function void put_byte(logic [7:0] b);
    name_buf = {name_buf, b};
  endfunction

  function void add_cont(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function void add_token();
    case ($urandom_range(0, 9))
      0: put_byte(8'($urandom_range(AsciiUpA, AsciiUpZ)));
      1: put_byte(8'($urandom_range(AsciiLoA, AsciiLoZ)));
      2: put_byte(8'($urandom_range(AsciiDig0, AsciiDig9)));
      3: begin
        put_byte(LeadLatin1);
        case ($urandom_range(0, 3))
          0:       put_byte(MulSign);
          1:       put_byte(DivSign);
          default: put_byte(8'($urandom_range(ContMin, ContMax)));
        endcase
      end
      4: begin
        // broken Latin-1 pair: next byte is outside the continuation range
        put_byte(LeadLatin1);
        if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 8'h7F)));
        else put_byte(8'($urandom_range(8'hC0, ByteLast)));
      end
      5: begin
        if ($urandom_range(0, 1)) put_byte(LeadLatin2);
        else put_byte(8'($urandom_range(LeadTwoMin, LeadTwoMax)));
        add_cont(1);
      end
      6: begin
        put_byte(8'($urandom_range(LeadThrMin, LeadThrMax)));
        add_cont(2);
      end
      7: begin
        put_byte(8'($urandom_range(LeadFouMin, LeadFouMax)));
        add_cont(3);
      end
      8: begin
        case ($urandom_range(0, 5))
          0:       put_byte("/");
          1:       put_byte("%");
          2:       put_byte(8'($urandom_range(ContMin, ContMax)));
          3:       put_byte(8'($urandom_range(8'hF5, ByteLast)));
          4:       put_byte(ByteNul);
          default: put_byte(8'($urandom_range(8'h20, 8'h2F)));
        endcase
      end
      default: put_byte(8'($urandom_range(0, 255)));
    endcase
  endfunction

  initial begin
    int n;
    int cut;
    rst_ni              = 1'b0;
    calm                = 1'b0;
    names               = 0;
    bytes_sent          = 0;
    idle_cycles         = 0;
    byte_if.valid       = 1'b0;
    byte_if.name_byte   = 8'h00;
    byte_if.end_of_name = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed names
    name_buf = '{8'h41};                                       send_name();
    name_buf = '{8'h30};                                       send_name();
    name_buf = '{8'h00};                                       send_name();
    name_buf = '{8'h2F, 8'h25, 8'hFF, 8'h80, 8'h39};           send_name();
    // multiply and divide signs skip only themselves
    name_buf = '{8'hC3, MulSign, 8'hC3, DivSign, 8'h7A};       send_name();
    name_buf = '{8'hC3, 8'hBF};                                send_name();
    name_buf = '{8'hC3, 8'h9F};                                send_name();
    name_buf = '{8'hC3, 8'h4D};                                send_name();
    // dropped byte is ignored even when zero
    name_buf = '{8'hC2, 8'h00, 8'h62};                         send_name();
    // name ends on the last byte of a four-byte sequence
    name_buf = '{8'hF4, 8'h41, 8'h42, 8'h43};                  send_name();
    name_buf = '{8'h5A, 8'h39};                                send_name();

    while (bytes_sent < 800) begin
      if (names % 25 == 0) calm = ($urandom_range(0, 3) == 0);
      name_buf.delete();
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) add_token();
        // some names are truncated, which can end them inside a sequence
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(1, name_buf.size());
          while (name_buf.size() > cut) void'(name_buf.pop_back());
        end
      end
      send_name();
    end

    byte_if.valid <= 1'b0;
    while (sb.bucket_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d names, %0d bytes (%0d scanned before a decision)",
             names, bytes_sent, sb.scanned);
    $display("%0d bucket items checked, %0d with a letter or digit found",
             sb.checked, sb.letters);
    if (sb.errors == 0 && sb.bucket_q.size() == 0) begin
      $display("utf8_name_bucket_mapper_unit_test passed");
    end else begin
      $display("utf8_name_bucket_mapper_unit_test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/unbm_pkg.sv
design/unbm_byte_if.sv
design/unbm_bucket_if.sv
design/unbm_classify.sv
design/unbm_scan.sv
design/utf8_name_bucket_mapper_unit.sv
tb/sv/utf8_name_bucket_mapper_unit_test.sv
